>>> rtl/rtc_pkg.sv
// Package with shared types and constants of the run table compressor.
package rtc_pkg;

	localparam int unsigned MAX_ENTRIES = 256;
	localparam int unsigned ADDR_W = $clog2(MAX_ENTRIES);
	localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

	localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
	localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;

	localparam logic [1:0] FUNC_PUSH = 2'd0;
	localparam logic [1:0] FUNC_FIND = 2'd1;
	localparam logic [1:0] FUNC_READ = 2'd2;
	localparam logic [1:0] FUNC_CLEAR = 2'd3;

	typedef struct packed {
		logic [1:0] func;
		logic [31:0] cell_value;
		logic last_cell;
		logic [31:0] base_index;
		logic [31:0] query_index;
		logic [7:0] entry_number;
		logic [30:0] capacity;
	} rtc_in_t;

	typedef struct packed {
		logic [8:0] added_count;
		logic found;
		logic [7:0] found_entry;
		logic read_ok;
		logic [31:0] entry_start;
		logic [31:0] entry_length;
		logic [31:0] entry_pattern;
		logic [63:0] entry_hash;
		logic [30:0] fill_count;
		logic [8:0] entry_count;
		logic [63:0] compressed_sum;
	} rtc_out_t;

	typedef struct packed {
		logic [31:0] start;
		logic [31:0] length;
		logic [31:0] value;
		logic [63:0] hash;
	} rtc_entry_t;

	// One FNV-1a byte step. The prime is 2^40 + 0x1b3, so the product is a
	// sum of shifted copies of the mixed hash.
	function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
		logic [63:0] x;
		x = h ^ {56'd0, b};
		fnv_step = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

endpackage

>>> rtl/rtc_if.sv
// Valid/ready channel interfaces for the run table compressor.
interface rtc_in_if import rtc_pkg::*; ();
	logic valid;
	logic ready;
	rtc_in_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface rtc_out_if import rtc_pkg::*; ();
	logic valid;
	logic ready;
	rtc_out_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface rtc_cfg_if ();
	logic valid;
	logic ready;
	logic [15:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/run_table_compressor.sv
// Run table compressor: run-length table with FNV-1a 64 run hashes.
// A push runs four FNV byte steps, the close step and the result step; on the last
// cell of a call the close step repeats to store the new run as well, and once more
// when that last cell also ends the previous run. A read goes through the read step,
// a clear straight to the result step; a find scans up to the first hit or all entries.
// One transaction at a time: the next is accepted the cycle after the result is taken.
// The table memory has no reset; every counter and run register is cleared by arst_n,
// and min_run resets to 2.
module run_table_compressor import rtc_pkg::*; (
	input logic clk,
	input logic arst_n,
	rtc_cfg_if.sink cfg,
	rtc_in_if.sink in_ch,
	rtc_out_if.source out_ch
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HASH,
		ST_CLOSE,
		ST_FIND,
		ST_READ,
		ST_OUT
	} state_t;

	state_t state_q;
	rtc_in_t item_q;
	rtc_out_t res_q;
	logic out_valid_q;
	logic [15:0] min_run_q;

	logic [CNT_W-1:0] stored_q;
	logic [63:0] total_q;
	logic [31:0] cur_value_q;
	logic [31:0] cur_start_q;
	logic [31:0] cur_len_q;
	logic [63:0] cur_hash_q;
	logic call_active_q;
	logic [8:0] call_added_q;

	// Hash being built for this cell, and its byte step count.
	logic [63:0] hash_q;
	logic [1:0] byte_q;
	// Run that must be closed before the new one opens.
	logic close_pend_q;
	rtc_entry_t close_q;

	// Table memory: one write port, one registered read port.
	rtc_entry_t mem [MAX_ENTRIES];
	logic mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	rtc_entry_t mem_wdata;
	logic [ADDR_W-1:0] mem_raddr;
	rtc_entry_t rd_q;
	logic [CNT_W-1:0] scan_q;
	logic scan_busy_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[mem_raddr];
	end

	logic [15:0] need;
	assign need = (min_run_q == 16'd0) ? 16'd1 : min_run_q;

	assign cfg.ready = 1'b1;
	assign in_ch.ready = (state_q == ST_IDLE) && !out_valid_q;
	assign out_ch.valid = out_valid_q;
	assign out_ch.payload = res_q;

	logic accept;
	assign accept = in_ch.valid && in_ch.ready;

	// The last cell closes the new run in the close step, after any pending run is stored.
	logic store_ok;
	logic [31:0] q_off;
	assign q_off = item_q.query_index - rd_q.start;

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = stored_q[ADDR_W-1:0];
		mem_wdata = close_q;
		if (state_q == ST_CLOSE) begin
			mem_we = store_ok;
		end
		mem_raddr = (state_q == ST_FIND) ? scan_q[ADDR_W-1:0] :
			in_ch.payload.entry_number[ADDR_W-1:0];
		if (state_q == ST_IDLE && accept && in_ch.payload.func == FUNC_FIND) begin
			mem_raddr = '0;
		end
	end

	assign store_ok = close_pend_q && (close_q.length >= {16'd0, need})
		&& (stored_q < CNT_W'(MAX_ENTRIES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			item_q <= '0;
			res_q <= '0;
			out_valid_q <= 1'b0;
			min_run_q <= 16'd2;
			stored_q <= '0;
			total_q <= '0;
			cur_value_q <= '0;
			cur_start_q <= '0;
			cur_len_q <= '0;
			cur_hash_q <= FNV_BASIS;
			call_active_q <= 1'b0;
			call_added_q <= '0;
			hash_q <= FNV_BASIS;
			close_pend_q <= 1'b0;
			close_q <= '0;
			scan_q <= '0;
			scan_busy_q <= 1'b0;
			byte_q <= '0;
		end else begin
			if (cfg.valid) begin
				min_run_q <= cfg.data;
			end
			if (out_ch.valid && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						item_q <= in_ch.payload;
						res_q <= '0;
						case (in_ch.payload.func)
							FUNC_PUSH: begin
								byte_q <= '0;
								close_q <= {cur_start_q, cur_len_q, cur_value_q, cur_hash_q};
								if (!call_active_q) begin
									close_pend_q <= 1'b0;
									call_active_q <= 1'b1;
									call_added_q <= '0;
									cur_value_q <= in_ch.payload.cell_value;
									cur_start_q <= in_ch.payload.base_index;
									cur_len_q <= 32'd1;
									hash_q <= FNV_BASIS;
								end else if (in_ch.payload.cell_value == cur_value_q) begin
									close_pend_q <= 1'b0;
									if (cur_len_q != 32'hFFFF_FFFF) begin
										cur_len_q <= cur_len_q + 32'd1;
									end
									hash_q <= cur_hash_q;
								end else begin
									close_pend_q <= 1'b1;
									cur_value_q <= in_ch.payload.cell_value;
									cur_start_q <= cur_start_q + cur_len_q;
									cur_len_q <= 32'd1;
									hash_q <= FNV_BASIS;
								end
								state_q <= ST_HASH;
							end
							FUNC_FIND: begin
								scan_q <= '0;
								scan_busy_q <= 1'b0;
								state_q <= ST_FIND;
							end
							FUNC_READ: begin
								state_q <= ST_READ;
							end
							default: begin
								stored_q <= '0;
								total_q <= '0;
								cur_value_q <= '0;
								cur_start_q <= '0;
								cur_len_q <= '0;
								cur_hash_q <= FNV_BASIS;
								call_active_q <= 1'b0;
								call_added_q <= '0;
								state_q <= ST_OUT;
							end
						endcase
					end
				end
				ST_HASH: begin
					hash_q <= fnv_step(hash_q, item_q.cell_value[8*byte_q +: 8]);
					byte_q <= byte_q + 2'd1;
					if (byte_q == 2'd3) begin
						state_q <= ST_CLOSE;
					end
				end
				ST_CLOSE: begin
					// Store the pending run, then on the last cell close the new one.
					if (store_ok) begin
						stored_q <= stored_q + CNT_W'(1);
						total_q <= total_q + {32'd0, close_q.length};
						call_added_q <= call_added_q + 9'd1;
					end
					if (item_q.last_cell && (close_pend_q || !byte_q[0])) begin
						if (!close_pend_q) begin
							close_pend_q <= 1'b1;
							close_q <= {cur_start_q, cur_len_q, cur_value_q, hash_q};
							byte_q <= 2'd1;
						end else begin
							close_pend_q <= 1'b0;
						end
					end else begin
						if (item_q.last_cell) begin
							res_q.added_count <= call_added_q + (store_ok ? 9'd1 : 9'd0);
							call_active_q <= 1'b0;
							call_added_q <= '0;
							cur_len_q <= '0;
							cur_hash_q <= FNV_BASIS;
						end else begin
							cur_hash_q <= hash_q;
						end
						close_pend_q <= 1'b0;
						state_q <= ST_OUT;
					end
				end
				ST_FIND: begin
					// rd_q holds entry scan_q - 1 once scan_busy_q is set.
					if (scan_busy_q && (item_q.query_index >= rd_q.start)
						&& (q_off < rd_q.length)) begin
						res_q.found <= 1'b1;
						res_q.found_entry <= 8'(scan_q - CNT_W'(1));
						state_q <= ST_OUT;
					end else if (scan_q >= stored_q) begin
						state_q <= ST_OUT;
					end else begin
						scan_q <= scan_q + CNT_W'(1);
						scan_busy_q <= 1'b1;
					end
				end
				ST_READ: begin
					if ({{(CNT_W > 8 ? CNT_W-8 : 0){1'b0}}, item_q.entry_number} < stored_q) begin
						res_q.read_ok <= 1'b1;
						res_q.entry_start <= rd_q.start;
						res_q.entry_length <= rd_q.length;
						res_q.entry_pattern <= rd_q.value;
						res_q.entry_hash <= rd_q.hash;
						res_q.fill_count <= (rd_q.length < {1'b0, item_q.capacity}) ?
							rd_q.length[30:0] : item_q.capacity;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					res_q.entry_count <= 9'(stored_q);
					res_q.compressed_sum <= total_q;
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The entry count never exceeds the table size.
	assert property (@(posedge clk) disable iff (!arst_n) stored_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count overflow");
	// No new item is taken while a result waits.
	assert property (@(posedge clk) disable iff (!arst_n) out_valid_q |-> !in_ch.ready)
		else $error("input taken while result pending");
	// The entry count grows by at most one per cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |=> (stored_q <= $past(stored_q) + CNT_W'(1)))
		else $error("entry count jumped");

endmodule

>>> sim/tb_top.sv
// Testbench for the run table compressor: queue-fed driver, monitor and predictor.
module tb_top;
	import rtc_pkg::*;

	typedef enum logic [1:0] {
		STIM_ITEM,
		STIM_CFG,
		STIM_DRAIN
	} stim_kind_t;

	typedef struct {
		stim_kind_t kind;
		logic [15:0] cfg_value;
		rtc_in_t item;
	} stim_t;

	// Clock and the single reset at the start of the run.
	logic clk;
	logic arst_n;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	rtc_cfg_if cfg_bus ();
	rtc_in_if cell_bus ();
	rtc_out_if result_bus ();

	run_table_compressor u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_bus.sink),
		.in_ch(cell_bus.sink),
		.out_ch(result_bus.source)
	);

	// Shadow state of the block, advanced once per accepted transaction.
	rtc_entry_t shadow_table [MAX_ENTRIES];
	int unsigned shadow_count;
	logic [63:0] shadow_total;
	logic [31:0] run_value;
	logic [31:0] run_origin;
	logic [31:0] run_length;
	logic [63:0] run_hash;
	logic in_call;
	int unsigned call_runs;
	logic [15:0] shadow_min_run;

	// Pending stimulus and the results still owed by the block.
	stim_t pending_cells [$];
	rtc_out_t owed_results [$];

	int unsigned error_count;
	int unsigned results_seen;
	int unsigned pushes_sent, finds_sent, reads_sent, clears_sent;
	int unsigned items_queued, items_sent;
	int unsigned src_idle_pct, sink_idle_pct;

	// Handshakes sampled at the rising edge, then used by the driver at the falling edge.
	logic cell_taken;
	logic cfg_taken;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want,
			results_seen);
		error_count++;
	endtask

	function automatic logic [63:0] absorb_word(input logic [63:0] h, input logic [31:0] w);
		logic [63:0] acc;
		acc = h;
		for (int k = 0; k < 4; k++) begin
			acc = acc ^ {56'd0, w[8*k +: 8]};
			acc = acc * FNV_PRIME;
		end
		return acc;
	endfunction

	function automatic void reset_shadow();
		shadow_count = 0;
		shadow_total = '0;
		run_value = '0;
		run_origin = '0;
		run_length = '0;
		run_hash = FNV_BASIS;
		in_call = 1'b0;
		call_runs = 0;
	endfunction

	// A run is stored when long enough and there is room left in the table.
	function automatic void close_current_run();
		logic [31:0] need;
		need = (shadow_min_run == 16'd0) ? 32'd1 : {16'd0, shadow_min_run};
		if (run_length >= need && shadow_count < MAX_ENTRIES) begin
			shadow_table[shadow_count] = '{run_origin, run_length, run_value, run_hash};
			shadow_count++;
			shadow_total = shadow_total + {32'd0, run_length};
			call_runs++;
		end
	endfunction

	function automatic void start_run(input logic [31:0] first, input logic [31:0] v);
		run_value = v;
		run_origin = first;
		run_length = 32'd1;
		run_hash = absorb_word(FNV_BASIS, v);
	endfunction

	// Predict the single result that one accepted transaction produces.
	function automatic rtc_out_t predict_result(input rtc_in_t c);
		rtc_out_t r;
		logic [31:0] next_start;
		rtc_entry_t e;
		r = '0;
		case (c.func)
			FUNC_PUSH: begin
				if (!in_call) begin
					in_call = 1'b1;
					call_runs = 0;
					start_run(c.base_index, c.cell_value);
				end else if (c.cell_value == run_value) begin
					if (run_length != 32'hFFFF_FFFF)
						run_length++;
					run_hash = absorb_word(run_hash, c.cell_value);
				end else begin
					next_start = run_origin + run_length;
					close_current_run();
					start_run(next_start, c.cell_value);
				end
				if (c.last_cell) begin
					close_current_run();
					r.added_count = call_runs[8:0];
					in_call = 1'b0;
					call_runs = 0;
					run_length = '0;
					run_hash = FNV_BASIS;
				end
			end
			FUNC_FIND: begin
				for (int i = 0; i < shadow_count; i++) begin
					e = shadow_table[i];
					if (c.query_index >= e.start && (c.query_index - e.start) < e.length) begin
						r.found = 1'b1;
						r.found_entry = i[7:0];
						break;
					end
				end
			end
			FUNC_READ: begin
				if (c.entry_number < shadow_count) begin
					e = shadow_table[c.entry_number];
					r.read_ok = 1'b1;
					r.entry_start = e.start;
					r.entry_length = e.length;
					r.entry_pattern = e.value;
					r.entry_hash = e.hash;
					r.fill_count = (e.length < {1'b0, c.capacity}) ? e.length[30:0] : c.capacity;
				end
			end
			default: begin
				reset_shadow();
			end
		endcase
		r.entry_count = shadow_count[8:0];
		r.compressed_sum = shadow_total;
		return r;
	endfunction

	// Stimulus builders.
	function automatic void queue_item(input rtc_in_t c);
		stim_t s;
		s.kind = STIM_ITEM;
		s.cfg_value = '0;
		s.item = c;
		pending_cells.push_back(s);
		items_queued++;
	endfunction

	function automatic void queue_cfg(input logic [15:0] v);
		stim_t s;
		s.kind = STIM_CFG;
		s.cfg_value = v;
		s.item = '0;
		pending_cells.push_back(s);
	endfunction

	function automatic void queue_drain();
		stim_t s;
		s.kind = STIM_DRAIN;
		s.cfg_value = '0;
		s.item = '0;
		pending_cells.push_back(s);
	endfunction

	function automatic rtc_in_t random_item(input logic [1:0] f);
		rtc_in_t c;
		c.func = f;
		c.cell_value = $urandom;
		c.last_cell = 1'($urandom_range(1));
		c.base_index = $urandom;
		c.query_index = $urandom;
		c.entry_number = 8'($urandom);
		c.capacity = 31'($urandom);
		return c;
	endfunction

	function automatic logic [31:0] pick_value();
		logic [31:0] v;
		case ($urandom_range(3))
			0: v = 32'h0000_0000;
			1: v = 32'hFFFF_FFFF;
			2: v = 32'h0000_005A;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic void queue_find(input logic [31:0] near);
		rtc_in_t c;
		c = random_item(FUNC_FIND);
		if ($urandom_range(3) != 0)
			c.query_index = near + $urandom_range(0, 40);
		queue_item(c);
	endfunction

	function automatic void queue_read(input int unsigned hi);
		rtc_in_t c;
		c = random_item(FUNC_READ);
		c.entry_number = 8'($urandom_range(0, hi));
		if ($urandom_range(1) != 0)
			c.capacity = 31'($urandom_range(0, 12));
		queue_item(c);
	endfunction

	function automatic void queue_clear();
		queue_item(random_item(FUNC_CLEAR));
	endfunction

	// One compress call; base_index is random on every cell after the first.
	function automatic void gen_call(input int unsigned len, input logic [31:0] base,
			input logic finish, input int unsigned repeat_pct);
		logic [31:0] v;
		rtc_in_t c;
		v = pick_value();
		for (int unsigned k = 0; k < len; k++) begin
			if (k != 0 && $urandom_range(99) >= repeat_pct)
				v = pick_value();
			c = random_item(FUNC_PUSH);
			c.cell_value = v;
			c.base_index = (k == 0) ? base : $urandom;
			c.last_cell = finish && (k == len - 1);
			queue_item(c);
		end
	endfunction

	// Driver: presents the next queued transaction after the falling edge.
	always @(negedge clk or negedge arst_n) begin
		stim_t nxt;
		logic in_hold;
		logic cfg_hold;
		if (!arst_n) begin
			cell_bus.valid <= 1'b0;
			cell_bus.payload <= '0;
			cfg_bus.valid <= 1'b0;
			cfg_bus.data <= '0;
		end else begin
			in_hold = cell_bus.valid && !cell_taken;
			cfg_hold = cfg_bus.valid && !cfg_taken;
			if (in_hold || cfg_hold) begin
				// The current transaction stays on the bus until it is accepted.
			end else if (pending_cells.size() == 0) begin
				cell_bus.valid <= 1'b0;
				cfg_bus.valid <= 1'b0;
			end else begin
				nxt = pending_cells[0];
				case (nxt.kind)
					STIM_CFG: begin
						cell_bus.valid <= 1'b0;
						if (owed_results.size() == 0) begin
							cfg_bus.valid <= 1'b1;
							cfg_bus.data <= nxt.cfg_value;
							void'(pending_cells.pop_front());
						end else begin
							cfg_bus.valid <= 1'b0;
						end
					end
					STIM_DRAIN: begin
						cell_bus.valid <= 1'b0;
						cfg_bus.valid <= 1'b0;
						if (owed_results.size() == 0)
							void'(pending_cells.pop_front());
					end
					default: begin
						cfg_bus.valid <= 1'b0;
						if ($urandom_range(99) < src_idle_pct) begin
							cell_bus.valid <= 1'b0;
						end else begin
							cell_bus.valid <= 1'b1;
							cell_bus.payload <= nxt.item;
							void'(pending_cells.pop_front());
							items_sent++;
							if (items_sent < 480) begin
								src_idle_pct = 15;
								sink_idle_pct = 60;
							end else if (items_sent < 960) begin
								src_idle_pct = 60;
								sink_idle_pct = 15;
							end else begin
								src_idle_pct = 0;
								sink_idle_pct = 0;
							end
						end
					end
				endcase
			end
		end
	end

	// Receiver: result ready with the idling of the current phase.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n)
			result_bus.ready <= 1'b0;
		else
			result_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	// Predictor: one prediction per accepted input transaction.
	always @(posedge clk) begin
		cell_taken <= cell_bus.valid && cell_bus.ready;
		if (arst_n && cell_bus.valid && cell_bus.ready) begin
			case (cell_bus.payload.func)
				FUNC_PUSH: pushes_sent++;
				FUNC_FIND: finds_sent++;
				FUNC_READ: reads_sent++;
				default: clears_sent++;
			endcase
			owed_results.push_back(predict_result(cell_bus.payload));
		end
	end

	always @(posedge clk) begin
		cfg_taken <= cfg_bus.valid && cfg_bus.ready;
		if (arst_n && cfg_bus.valid && cfg_bus.ready)
			shadow_min_run = cfg_bus.data;
	end

	// Monitor: compares each accepted result with the oldest prediction.
	always @(posedge clk) begin
		rtc_out_t got, want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			got = result_bus.payload;
			results_seen++;
			if (owed_results.size() == 0) begin
				report_mismatch("unexpected result", 64'd0, 64'd0);
			end else begin
				want = owed_results.pop_front();
				if (got.added_count !== want.added_count)
					report_mismatch("added_count", 64'(got.added_count), 64'(want.added_count));
				if (got.found !== want.found)
					report_mismatch("found", 64'(got.found), 64'(want.found));
				if (got.found_entry !== want.found_entry)
					report_mismatch("found_entry", 64'(got.found_entry), 64'(want.found_entry));
				if (got.read_ok !== want.read_ok)
					report_mismatch("read_ok", 64'(got.read_ok), 64'(want.read_ok));
				if (got.entry_start !== want.entry_start)
					report_mismatch("entry_start", 64'(got.entry_start), 64'(want.entry_start));
				if (got.entry_length !== want.entry_length)
					report_mismatch("entry_length", 64'(got.entry_length),
						64'(want.entry_length));
				if (got.entry_pattern !== want.entry_pattern)
					report_mismatch("entry_pattern", 64'(got.entry_pattern),
						64'(want.entry_pattern));
				if (got.entry_hash !== want.entry_hash)
					report_mismatch("entry_hash", got.entry_hash, want.entry_hash);
				if (got.fill_count !== want.fill_count)
					report_mismatch("fill_count", 64'(got.fill_count), 64'(want.fill_count));
				if (got.entry_count !== want.entry_count)
					report_mismatch("entry_count", 64'(got.entry_count), 64'(want.entry_count));
				if (got.compressed_sum !== want.compressed_sum)
					report_mismatch("compressed_sum", got.compressed_sum,
						want.compressed_sum);
			end
		end
	end

	// Stimulus, reset and the end of the run.
	initial begin
		logic [31:0] base;
		arst_n = 1'b0;
		error_count = 0;
		results_seen = 0;
		pushes_sent = 0;
		finds_sent = 0;
		reads_sent = 0;
		clears_sent = 0;
		items_queued = 0;
		items_sent = 0;
		src_idle_pct = 15;
		sink_idle_pct = 60;
		reset_shadow();
		shadow_min_run = 16'd2;

		// Short calls with the reset min_run, some starting just below the index wrap.
		queue_cfg(16'd2);
		for (int n = 0; n < 55; n++) begin
			base = $urandom;
			if (n % 9 == 4)
				base = 32'hFFFF_FFF8;
			if (n == 30) begin
				gen_call(5, base, 1'b0, 50);
				queue_clear();
			end
			gen_call($urandom_range(1, 16), base, 1'b1, 60);
			repeat ($urandom_range(0, 3)) begin
				if ($urandom_range(1) != 0)
					queue_find(base);
				else
					queue_read(24);
			end
		end
		queue_drain();

		// One long call that fills the table and drops the runs beyond it.
		queue_cfg(16'd1);
		base = $urandom;
		gen_call(350, base, 1'b1, 15);
		for (int n = 0; n < 24; n++) begin
			queue_find(base + 32'($urandom_range(0, 320)));
			queue_read(255);
		end
		queue_drain();

		// A min_run nothing can reach, then min_run zero.
		queue_clear();
		queue_cfg(16'hFFFF);
		for (int n = 0; n < 4; n++) begin
			base = $urandom;
			gen_call($urandom_range(1, 12), base, 1'b1, 70);
			queue_find(base);
		end
		queue_cfg(16'd0);
		for (int n = 0; n < 2; n++) begin
			base = $urandom;
			gen_call($urandom_range(1, 12), base, 1'b1, 50);
			queue_read(8);
		end
		queue_clear();
		queue_drain();

		queue_cfg(16'd3);
		while (items_queued < 1440) begin
			base = $urandom;
			gen_call($urandom_range(1, 20), base, 1'b1, 70);
			if ($urandom_range(1) != 0)
				queue_find(base);
			else
				queue_read(40);
			if ($urandom_range(19) == 0)
				queue_clear();
		end

		repeat (4) @(posedge clk);
		#3 arst_n = 1'b1;

		while (pending_cells.size() != 0 || owed_results.size() != 0
			|| cell_bus.valid || cfg_bus.valid)
			@(posedge clk);
		repeat (3) @(posedge clk);

		$display("Covered %0d pushes, %0d finds, %0d reads and %0d clears over a full table,",
			pushes_sent, finds_sent, reads_sent, clears_sent);
		$display("wrapped start indices, several min_run values and both stall patterns.");
		if (error_count == 0 && results_seen == items_sent)
			$display("run_table_compressor test passed");
		else
			$display("run_table_compressor test failed");
		$finish;
	end

	// Hard limit on the run time.
	initial begin
		#20_000_000;
		$display("Run stopped at the time limit with %0d results seen.", results_seen);
		$display("run_table_compressor test failed");
		$finish;
	end

endmodule

>>> filelist.f
rtl/rtc_pkg.sv
rtl/rtc_if.sv
rtl/run_table_compressor.sv
sim/tb_top.sv
